@@ src/sfdl_pkg.sv @@
`default_nettype none

package sfdl_pkg;

    // Store geometry and field widths
    localparam int BUFFER_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int LEN_W        = ADDR_W + 1;
    localparam int SAMPLE_W     = 24;
    localparam int FRAC_W       = 16;
    localparam int DELAY_W      = ADDR_W + FRAC_W;
    localparam int RATE_W       = 17;

    // Smoother product: signed delay difference times signed rate
    localparam int DIFF_W       = DELAY_W + 1;
    localparam int PROD_W       = DIFF_W + RATE_W + 1;
    localparam int STEP_W       = PROD_W - 16;

    // Interpolation: sample times signed weight, plus one guard bit for the sum
    localparam int WEIGHT_W     = FRAC_W + 1;
    localparam int MAC_W        = SAMPLE_W + WEIGHT_W + 1;
    localparam int ACC_W        = MAC_W + 1;
    localparam int RES_W        = ACC_W - FRAC_W;

    // Constants
    localparam logic [LEN_W-1:0]    LEN_MIN   = LEN_W'(2);
    localparam logic [LEN_W-1:0]    LEN_MAX   = LEN_W'(BUFFER_DEPTH);
    localparam logic [RATE_W-1:0]   RATE_ONE  = RATE_W'(65536);
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_W;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_BUFFER_LENGTH  = 2'd0;
    localparam logic [1:0] REG_TARGET_DELAY   = 2'd1;
    localparam logic [1:0] REG_SMOOTHING_RATE = 2'd2;
    localparam logic [LEN_W-1:0]   BUFFER_LENGTH_RST  = LEN_W'(4096);
    localparam logic [DELAY_W-1:0] TARGET_DELAY_RST   = '0;
    localparam logic [RATE_W-1:0]  SMOOTHING_RATE_RST = RATE_W'(68);

    // Controller to datapath commands, one per step of an item
    typedef struct packed {
        logic load;     // capture the incoming sample
        logic prep;     // clamp ring length, positions and delays
        logic mul;      // smoother multiply, write sample into store
        logic upd;      // update the current delay
        logic idx;      // form the first read index and weights
        logic rd1;      // read first tap, form second index
        logic rd2;      // read second tap, first product
        logic mac;      // second product and sum
        logic out_load; // round, saturate and load the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clear_done; // store clearing pass finished
        logic out_free;   // output register can take a result
    } t_status;

endpackage

`default_nettype wire

@@ src/sfdl_ctrl.sv @@
`default_nettype none

module sfdl_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire sfdl_pkg::t_status i_status,
    output sfdl_pkg::t_cmd        o_cmd
);
    import sfdl_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_PREP  = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_UPD   = 4'd4;
    localparam logic [3:0] ST_IDX   = 4'd5;
    localparam logic [3:0] ST_RD1   = 4'd6;
    localparam logic [3:0] ST_RD2   = 4'd7;
    localparam logic [3:0] ST_MAC   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (i_status.clear_done) n_state = ST_IDLE;
            ST_IDLE:  if (i_valid) n_state = ST_PREP;
            ST_PREP:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_UPD;
            ST_UPD:   n_state = ST_IDX;
            ST_IDX:   n_state = ST_RD1;
            ST_RD1:   n_state = ST_RD2;
            ST_RD2:   n_state = ST_MAC;
            ST_MAC:   n_state = ST_OUT;
            ST_OUT:   if (i_status.out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode commands
    assign o_ready        = (r_state == ST_IDLE);
    assign o_cmd.load     = (r_state == ST_IDLE) && i_valid;
    assign o_cmd.prep     = (r_state == ST_PREP);
    assign o_cmd.mul      = (r_state == ST_MUL);
    assign o_cmd.upd      = (r_state == ST_UPD);
    assign o_cmd.idx      = (r_state == ST_IDX);
    assign o_cmd.rd1      = (r_state == ST_RD1);
    assign o_cmd.rd2      = (r_state == ST_RD2);
    assign o_cmd.mac      = (r_state == ST_MAC);
    assign o_cmd.out_load = (r_state == ST_OUT) && i_status.out_free;

`ifndef SYNTHESIS
    // No item is taken before the store is cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_status.clear_done |-> !o_ready)
        else $error("item accepted during clearing pass");

    // An accepted transfer always moves on to the clamp step
    a_load_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.prep)
        else $error("accepted item did not start processing");

    // Result waits in the last step while the output register is busy
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) && !i_status.out_free |=> (r_state == ST_OUT))
        else $error("result step left while output busy");
`endif

endmodule

`default_nettype wire

@@ src/sfdl_dp.sv @@
`default_nettype none

module sfdl_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire sfdl_pkg::t_cmd                 i_cmd,
    output sfdl_pkg::t_status                   o_status,
    input  wire logic signed [sfdl_pkg::SAMPLE_W-1:0] i_sample_in,
    input  wire logic [sfdl_pkg::LEN_W-1:0]     i_buffer_length,
    input  wire logic [sfdl_pkg::DELAY_W-1:0]   i_target_delay,
    input  wire logic [sfdl_pkg::RATE_W-1:0]    i_smoothing_rate,
    input  wire logic                           i_ready,
    output logic                                o_valid,
    output logic signed [sfdl_pkg::SAMPLE_W-1:0] o_sample_out
);
    import sfdl_pkg::*;

    // Sample store and clearing pass
    logic signed [SAMPLE_W-1:0] r_mem [0:BUFFER_DEPTH-1];
    logic signed [SAMPLE_W-1:0] r_rdata;
    logic [LEN_W-1:0]           r_clr_cnt;
    logic                       clr_done;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic signed [SAMPLE_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]          mem_raddr;

    // Item state
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [ADDR_W-1:0]          r_wp;
    logic [DELAY_W-1:0]         r_cur;
    logic                       r_first;

    // Per-item working registers
    logic [LEN_W-1:0]           r_len;
    logic [ADDR_W-1:0]          r_wpe;
    logic [DELAY_W-1:0]         r_maxd;
    logic [DELAY_W-1:0]         r_tgt;
    logic [RATE_W-1:0]          r_rate;
    logic signed [PROD_W-1:0]   r_prod;
    logic [ADDR_W-1:0]          r_idx1;
    logic [ADDR_W-1:0]          r_idx2;
    logic [WEIGHT_W-1:0]        r_w1;
    logic [WEIGHT_W-1:0]        r_w2;
    logic signed [ACC_W-1:0]    r_acc;

    // Output register
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out;

    // Clamp step signals
    logic [LEN_W-1:0]           len_c;
    logic [ADDR_W-1:0]          wp_c;
    logic [DELAY_W-1:0]         maxd_c;
    logic [DELAY_W-1:0]         tgt_c;
    logic [DELAY_W-1:0]         cur_c;
    logic [RATE_W-1:0]          rate_c;
    logic [LEN_W-1:0]           wp_inc;

    // Smoother signals
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   prod_rnd;
    logic signed [STEP_W-1:0]   step;
    logic signed [DELAY_W+3:0]  nd;
    logic [DELAY_W-1:0]         nd_c;

    // Index signals
    logic [ADDR_W-1:0]          di;
    logic [FRAC_W-1:0]          frac;
    logic                       frac_zero;
    logic [LEN_W:0]             tap;
    logic [LEN_W:0]             tap_wrap;
    logic [ADDR_W-1:0]          idx1_c;
    logic [LEN_W-1:0]           idx2_inc;

    // Interpolation signals
    logic signed [MAC_W-1:0]    mul1;
    logic signed [MAC_W-1:0]    mul2;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [RES_W-1:0]    res;
    logic signed [SAMPLE_W-1:0] res_sat;

    localparam logic signed [RES_W-1:0] SAT_MAX =
        RES_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
    localparam logic signed [RES_W-1:0] SAT_MIN = -SAT_MAX - RES_W'(1);

    // Clear the store entry by entry after reset
    assign clr_done = r_clr_cnt[ADDR_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (!clr_done) begin
            r_clr_cnt <= r_clr_cnt + LEN_W'(1);
        end
    end

    // Store write and registered read
    assign mem_we    = !clr_done || i_cmd.mul;
    assign mem_waddr = clr_done ? r_wpe : r_clr_cnt[ADDR_W-1:0];
    assign mem_wdata = clr_done ? r_sample : '0;
    assign mem_raddr = i_cmd.rd2 ? r_idx2 : r_idx1;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // Clamp ring length, write position, target, current delay and rate
    always_comb begin
        if (i_buffer_length < LEN_MIN) begin
            len_c = LEN_MIN;
        end else if (i_buffer_length > LEN_MAX) begin
            len_c = LEN_MAX;
        end else begin
            len_c = i_buffer_length;
        end
        wp_c   = ({1'b0, r_wp} >= len_c) ? '0 : r_wp;
        maxd_c = {ADDR_W'(len_c - LEN_W'(1)), {FRAC_W{1'b0}}};
        tgt_c  = (i_target_delay > maxd_c) ? maxd_c : i_target_delay;
        if (r_first) begin
            cur_c = tgt_c;
        end else begin
            cur_c = (r_cur > maxd_c) ? maxd_c : r_cur;
        end
        rate_c = (i_smoothing_rate > RATE_ONE) ? RATE_ONE : i_smoothing_rate;
    end

    // Smoother: multiply, then round and add
    assign diff     = $signed({1'b0, r_tgt}) - $signed({1'b0, r_cur});
    assign prod     = PROD_W'(diff * $signed({1'b0, r_rate}));
    assign prod_rnd = r_prod + PROD_W'(32768);
    assign step     = prod_rnd[PROD_W-1:16];
    assign nd       = $signed({4'b0, r_cur}) + (DELAY_W+4)'(step);
    assign wp_inc   = {1'b0, r_wpe} + LEN_W'(1);

    always_comb begin
        if (nd < 0) begin
            nd_c = '0;
        end else if (nd > $signed({4'b0, r_maxd})) begin
            nd_c = r_maxd;
        end else begin
            nd_c = nd[DELAY_W-1:0];
        end
    end

    // Read index behind the write position, wrapped once into the ring
    assign di        = r_cur[DELAY_W-1:FRAC_W];
    assign frac      = r_cur[FRAC_W-1:0];
    assign frac_zero = (frac == '0);
    assign tap       = {2'b0, r_wpe} + {1'b0, r_len} - {2'b0, di}
                       - (LEN_W+1)'(!frac_zero);
    assign tap_wrap  = tap - {1'b0, r_len};
    assign idx1_c    = (tap >= {1'b0, r_len}) ? tap_wrap[ADDR_W-1:0] : tap[ADDR_W-1:0];
    assign idx2_inc  = {1'b0, r_idx1} + LEN_W'(1);

    // Interpolate: older tap times fraction, newer tap times the rest
    assign mul1    = MAC_W'(r_rdata * $signed({1'b0, r_w1}));
    assign mul2    = MAC_W'(r_rdata * $signed({1'b0, r_w2}));
    assign acc_rnd = r_acc + ACC_W'(2 ** (FRAC_W - 1));
    assign res     = acc_rnd[ACC_W-1:FRAC_W];

    always_comb begin
        if (res > SAT_MAX) begin
            res_sat = SAT_MAX[SAMPLE_W-1:0];
        end else if (res < SAT_MIN) begin
            res_sat = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            res_sat = res[SAMPLE_W-1:0];
        end
    end

    // Item state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_cur   <= '0;
            r_first <= 1'b1;
        end else begin
            if (i_cmd.prep) begin
                r_cur   <= cur_c;
                r_first <= 1'b0;
            end else if (i_cmd.upd) begin
                r_cur <= nd_c;
            end
            if (i_cmd.mul) begin
                r_wp <= (wp_inc == r_len) ? '0 : wp_inc[ADDR_W-1:0];
            end
        end
    end

    // Working registers, advanced step by step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample_in;
        end
        if (i_cmd.prep) begin
            r_len  <= len_c;
            r_wpe  <= wp_c;
            r_maxd <= maxd_c;
            r_tgt  <= tgt_c;
            r_rate <= rate_c;
        end
        if (i_cmd.mul) begin
            r_prod <= prod;
        end
        if (i_cmd.idx) begin
            r_idx1 <= idx1_c;
            r_w1   <= frac_zero ? WEIGHT_ONE : {1'b0, frac};
            r_w2   <= frac_zero ? '0 : (WEIGHT_ONE - {1'b0, frac});
        end
        if (i_cmd.rd1) begin
            r_idx2 <= (idx2_inc == r_len) ? '0 : idx2_inc[ADDR_W-1:0];
        end
        if (i_cmd.rd2) begin
            r_acc <= ACC_W'(mul1);
        end else if (i_cmd.mac) begin
            r_acc <= r_acc + ACC_W'(mul2);
        end
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= res_sat;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_sample_out        = r_out;
    assign o_status.clear_done = clr_done;
    assign o_status.out_free   = !r_out_valid || i_ready;

`ifndef SYNTHESIS
    // Smoothed delay never passes the ring's maximum
    a_cur_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.idx |-> (r_cur <= r_maxd))
        else $error("current delay beyond maximum");

    // Both taps fall inside the ring
    a_taps_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd2 |-> ({1'b0, r_idx1} < r_len) && ({1'b0, r_idx2} < r_len))
        else $error("read tap outside ring");

    // Write position wraps inside the ring
    a_wp_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul |=> ({1'b0, r_wp} < r_len))
        else $error("write position outside ring");

    // No sample write while the clearing pass runs
    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !clr_done |-> !i_cmd.mul)
        else $error("sample written during clearing pass");
`endif

endmodule

`default_nettype wire

@@ src/smoothed_fractional_delay_line.sv @@
// Steps per item: prep, mul, upd, idx, rd1, rd2, mac, then out loads the output register
// and waits while it is busy. A new item is taken only in idle, set by the step sequence
// of the controller, which shares one store read port for both taps and steps the smoother
// and mixer. Reset: synchronous, active low; afterwards a clearing pass zeroes the store
// of 4096 entries, during which no item is taken (register writes are accepted).
`default_nettype none

module smoothed_fractional_delay_line (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Input channel
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [sfdl_pkg::SAMPLE_W-1:0] i_sample_in,
    // Output channel
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic signed [sfdl_pkg::SAMPLE_W-1:0]      o_sample_out,
    // Configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [sfdl_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [sfdl_pkg::PDATA_W-1:0]         pwdata,
    output logic [sfdl_pkg::PDATA_W-1:0]              prdata,
    output logic                                      pready
);
    import sfdl_pkg::*;

    logic [LEN_W-1:0]   r_buffer_length;
    logic [DELAY_W-1:0] r_target_delay;
    logic [RATE_W-1:0]  r_smoothing_rate;
    logic               cfg_wr;
    logic [1:0]         cfg_idx;
    t_cmd               cmd;
    t_status            status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_length  <= BUFFER_LENGTH_RST;
            r_target_delay   <= TARGET_DELAY_RST;
            r_smoothing_rate <= SMOOTHING_RATE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BUFFER_LENGTH:  r_buffer_length  <= pwdata[LEN_W-1:0];
                REG_TARGET_DELAY:   r_target_delay   <= pwdata[DELAY_W-1:0];
                REG_SMOOTHING_RATE: r_smoothing_rate <= pwdata[RATE_W-1:0];
                default:            ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (cfg_idx)
            REG_BUFFER_LENGTH:  prdata = PDATA_W'(r_buffer_length);
            REG_TARGET_DELAY:   prdata = PDATA_W'(r_target_delay);
            REG_SMOOTHING_RATE: prdata = PDATA_W'(r_smoothing_rate);
            default:            prdata = '0;
        endcase
    end

    sfdl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    sfdl_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_sample_in      (i_sample_in),
        .i_buffer_length  (r_buffer_length),
        .i_target_delay   (r_target_delay),
        .i_smoothing_rate (r_smoothing_rate),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_sample_out     (o_sample_out)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_smoothed_fractional_delay_line.sv @@
`timescale 1ns / 100ps

import sfdl_pkg::*;

// Tracks the delay line state and checks every delayed sample in order
class delay_tap_checker;
    logic signed [SAMPLE_W-1:0] taps [BUFFER_DEPTH];
    longint                     wr_pos;
    longint                     cur_delay;
    bit                         first_pending;
    logic [LEN_W-1:0]           len_reg;
    logic [DELAY_W-1:0]         target_reg;
    logic [RATE_W-1:0]          rate_reg;
    logic signed [SAMPLE_W-1:0] expected_taps [$];
    int                         mismatches;

    function new();
        foreach (taps[k]) taps[k] = '0;
        wr_pos        = 0;
        cur_delay     = 0;
        first_pending = 1'b1;
        len_reg       = BUFFER_LENGTH_RST;
        target_reg    = TARGET_DELAY_RST;
        rate_reg      = SMOOTHING_RATE_RST;
        mismatches    = 0;
    endfunction

    // Mirror a register write, keeping only the implemented bits
    function void write_reg(logic [1:0] reg_idx, logic [PDATA_W-1:0] value);
        case (reg_idx)
            REG_BUFFER_LENGTH:  len_reg    = value[LEN_W-1:0];
            REG_TARGET_DELAY:   target_reg = value[DELAY_W-1:0];
            REG_SMOOTHING_RATE: rate_reg   = value[RATE_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the delay, store the sample and predict the interpolated tap
    function void note_input(logic signed [SAMPLE_W-1:0] sample);
        longint len, max_d, tgt, rate, diff, nd, whole, frac;
        longint idx_a, idx_b, wt_b, acc, res, smax, smin;
        len = len_reg;
        if (len < 2) len = 2;
        if (len > BUFFER_DEPTH) len = BUFFER_DEPTH;
        if (wr_pos >= len) wr_pos = 0;
        max_d = (len - 1) << FRAC_W;
        tgt = target_reg;
        if (tgt > max_d) tgt = max_d;
        if (cur_delay > max_d) cur_delay = max_d;
        if (first_pending) begin
            cur_delay     = tgt;
            first_pending = 1'b0;
        end
        rate = rate_reg;
        if (rate > longint'(RATE_ONE)) rate = longint'(RATE_ONE);

        // One-pole smoother step, rounded half up
        diff = tgt - cur_delay;
        nd = cur_delay + ((diff * rate + 32768) >>> 16);
        if (nd < 0) nd = 0;
        if (nd > max_d) nd = max_d;
        cur_delay = nd;

        // Pick the two taps and their weights
        whole = cur_delay >> FRAC_W;
        frac  = cur_delay & ((longint'(1) << FRAC_W) - 1);
        if (frac == 0) begin
            idx_a = (wr_pos + len - whole) % len;
            wt_b  = 0;
        end else begin
            idx_a = (wr_pos + len - whole - 1) % len;
            wt_b  = (longint'(1) << FRAC_W) - frac;
        end
        idx_b = (idx_a + 1) % len;

        taps[wr_pos] = sample;
        wr_pos = (wr_pos + 1) % len;

        // Mix, round half up, saturate
        acc = longint'(taps[idx_a]) * ((longint'(1) << FRAC_W) - wt_b)
            + longint'(taps[idx_b]) * wt_b;
        res = (acc + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
        smax = (longint'(1) << (SAMPLE_W - 1)) - 1;
        smin = -smax - 1;
        if (res > smax) res = smax;
        if (res < smin) res = smin;
        expected_taps.push_back(SAMPLE_W'(res));
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] actual);
        logic signed [SAMPLE_W-1:0] want;
        if (expected_taps.size() == 0) begin
            $display("%0t ns: sample_out expected none, got %0d", $time, actual);
            mismatches++;
        end else begin
            want = expected_taps.pop_front();
            if (actual !== want) begin
                $display("%0t ns: sample_out expected %0d, got %0d", $time, want, actual);
                mismatches++;
            end
        end
    endfunction

    function int pending();
        return expected_taps.size();
    endfunction
endclass

module tb_smoothed_fractional_delay_line;

    localparam int STALL_LIMIT     = 20000;
    localparam int ITEMS_PER_PHASE = 123;
    localparam int RANDOM_PHASES   = 10;
    localparam int STEADY_PHASE    = 4;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [PADDR_W-1:0]         paddr = '0;
    logic [PDATA_W-1:0]         pwdata = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    bit                         steady = 1'b0;
    int                         stall_cycles = 0;
    delay_tap_checker           sb;

    smoothed_fractional_delay_line dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample_in  (i_sample_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample_out (o_sample_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #6 i_clk = ~i_clk;

    // Number of idle cycles before the next transfer, each added with odds of 34 in 100; zero when steady
    function automatic int idle_gap();
        int n;
        n = 0;
        if (steady) return 0;
        while ($urandom_range(99) < 34) n++;
        return n;
    endfunction

    // Receiver: stall at random unless steady, check each transfer
    always @(negedge i_clk) begin
        i_ready <= steady || ($urandom_range(99) >= 34);
    end

    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            sb.check_result(o_sample_out);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Pad unused register bits with random garbage half the time
    function automatic logic [PDATA_W-1:0] pad_word(logic [PDATA_W-1:0] value, int width);
        logic [PDATA_W-1:0] mask;
        mask = (PDATA_W'(1) << width) - 1;
        if ($urandom_range(1) == 1) return ($urandom & ~mask) | (value & mask);
        return value;
    endfunction

    // One APB write: setup then access; the bus stays selected for the next write
    task automatic write_register(input logic [1:0] reg_idx, input logic [PDATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'({reg_idx, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(reg_idx, value);
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [PDATA_W-1:0] len_word,
                              input logic [PDATA_W-1:0] target_word,
                              input logic [PDATA_W-1:0] rate_word);
        write_register(REG_BUFFER_LENGTH, len_word);
        write_register(REG_TARGET_DELAY, target_word);
        write_register(REG_SMOOTHING_RATE, rate_word);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
    endtask

    // Offer one sample and hold it until the transfer; called at a falling edge
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_sample_in = sample;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(sample);
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every outstanding delayed sample
    task automatic drain();
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_phase();
        logic [PDATA_W-1:0] len_val, tgt_val, rate_val;
        longint             eff, whole;
        case ($urandom_range(9))
            0:       len_val = 2;
            1:       len_val = BUFFER_DEPTH;
            2:       len_val = $urandom_range(1);
            3:       len_val = $urandom_range(8191, 4097);
            4, 5, 6: len_val = $urandom_range(64, 2);
            default: len_val = $urandom_range(BUFFER_DEPTH, 2);
        endcase
        eff = len_val;
        if (eff < 2) eff = 2;
        if (eff > BUFFER_DEPTH) eff = BUFFER_DEPTH;
        whole = $urandom_range(32'(eff - 1));
        case ($urandom_range(5))
            0:       tgt_val = 0;
            1:       tgt_val = PDATA_W'((eff - 1) << FRAC_W);
            2:       tgt_val = $urandom_range(28'hFFFFFFF);
            3:       tgt_val = PDATA_W'(whole << FRAC_W);
            default: tgt_val = PDATA_W'((whole << FRAC_W) | $urandom_range(65535, 1));
        endcase
        case ($urandom_range(7))
            0:       rate_val = 0;
            1:       rate_val = RATE_ONE;
            2:       rate_val = $urandom_range(131071, 65537);
            3:       rate_val = 1;
            4:       rate_val = SMOOTHING_RATE_RST;
            default: rate_val = $urandom_range(65536);
        endcase
        set_config(pad_word(len_val, LEN_W), pad_word(tgt_val, DELAY_W),
                   pad_word(rate_val, RATE_W));
        repeat (ITEMS_PER_PHASE) send_sample(SAMPLE_W'($urandom));
        drain();
    endtask

    initial begin
        logic signed [SAMPLE_W-1:0] corner_samples [10];
        corner_samples = '{
            24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF, 24'sh000001,
            24'shAAAAAA, 24'sh555555, 24'sh7FFFFF, 24'sh800000, 24'sh000100
        };
        sb = new();

        // Hold reset, then release at a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // First item jumps straight to a 5.25-frame delay; garbage in unused bits
        set_config(32'd16, 32'hF005_4000, 32'd65536);
        foreach (corner_samples[k]) send_sample(corner_samples[k]);
        drain();

        // Shorten the ring: write position and current delay both fall outside it
        set_config(32'd4, 32'hFFFF_FFFF, 32'd0);
        repeat (3) send_sample(SAMPLE_W'($urandom));
        drain();

        // Ring length below the minimum, zero delay, rate above one
        set_config(32'hFFFF_E001, 32'd0, 32'd131071);
        repeat (3) send_sample(SAMPLE_W'($urandom));
        drain();

        // Ring length zero with a fractional target past the end
        set_config(32'd0, 32'h0001_8000, 32'd70000);
        repeat (2) send_sample(SAMPLE_W'($urandom));
        drain();

        // Ring length above the store depth, deepest delay, default smoothing
        set_config(32'hFFFF_FFFF, {4'h0, 12'hFFF, 16'hFFFF}, 32'd68);
        repeat (3) send_sample(SAMPLE_W'($urandom));
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            steady = (p == STEADY_PHASE);
            random_phase();
        end
        steady = 1'b0;

        // Let any stray output show up before the verdict
        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
